### rtl/core/bemf_zero_cross_commutator_defines.svh
// assertion macros for the back-emf zero-crossing commutator checker
// no dependencies, included by the checker file only
`ifndef BEMF_ZERO_CROSS_COMMUTATOR_DEFINES_SVH
`define BEMF_ZERO_CROSS_COMMUTATOR_DEFINES_SVH

// same-cycle implication
`define BZC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BZC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/bzc_pkg.sv
// shared types and constants for the back-emf zero-crossing commutator
// no dependencies, compiled before every module of the block
package bzc_pkg;

   localparam int SAMPLE_BITS_DEF = 12;
   localparam int FIELD_W         = 12;
   localparam int STEP_W          = 3;
   localparam int COUNT_W         = 8;

   localparam logic [STEP_W-1:0]  STEP_1 = 3'd1;
   localparam logic [STEP_W-1:0]  STEP_2 = 3'd2;
   localparam logic [STEP_W-1:0]  STEP_3 = 3'd3;
   localparam logic [STEP_W-1:0]  STEP_4 = 3'd4;
   localparam logic [STEP_W-1:0]  STEP_5 = 3'd5;
   localparam logic [STEP_W-1:0]  STEP_6 = 3'd6;
   localparam logic [STEP_W-1:0]  STEP_FIRST = STEP_1;
   localparam logic [STEP_W-1:0]  STEP_LAST  = STEP_6;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd3;

   typedef struct packed {
      logic [FIELD_W-1:0] phase_a_sample;
      logic [FIELD_W-1:0] phase_b_sample;
      logic [FIELD_W-1:0] phase_c_sample;
   } bzc_req_type;

   typedef struct packed {
      logic               commutate;
      logic [STEP_W-1:0]  step_now;
      logic [COUNT_W-1:0] qualify_count;
   } bzc_rsp_type;

   typedef struct packed {
      logic [STEP_W-1:0]  step;
      logic [COUNT_W-1:0] count;
   } bzc_state_type;

endpackage

### rtl/core/bzc_step_unit.sv
// zero-crossing detect, filter counter and step advance for one sample triple
// depends on bzc_pkg
module bzc_step_unit #(
   parameter int SAMPLE_BITS = bzc_pkg::SAMPLE_BITS_DEF
) (
   input  bzc_pkg::bzc_req_type        sample_data,
   input  bzc_pkg::bzc_state_type      state_cur,
   input  logic [bzc_pkg::COUNT_W-1:0] filter_limit,
   output bzc_pkg::bzc_state_type      state_next,
   output bzc_pkg::bzc_rsp_type        result
);
   import bzc_pkg::*;

   localparam int USE_BITS = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
   localparam int SUM_W    = SAMPLE_BITS + 2;

   logic [SAMPLE_BITS-1:0] a_val, b_val, c_val;
   logic [SUM_W-1:0]       sum_val, a_x3, b_x3, c_x3;
   logic                   a_above, b_above, c_above;
   logic                   a_below, b_below, c_below;
   logic                   hit, step_ok, fire;

   assign a_val = SAMPLE_BITS'(sample_data.phase_a_sample[USE_BITS-1:0]);
   assign b_val = SAMPLE_BITS'(sample_data.phase_b_sample[USE_BITS-1:0]);
   assign c_val = SAMPLE_BITS'(sample_data.phase_c_sample[USE_BITS-1:0]);

   assign sum_val = SUM_W'(a_val) + SUM_W'(b_val) + SUM_W'(c_val);
   assign a_x3    = (SUM_W'(a_val) << 1) + SUM_W'(a_val);
   assign b_x3    = (SUM_W'(b_val) << 1) + SUM_W'(b_val);
   assign c_x3    = (SUM_W'(c_val) << 1) + SUM_W'(c_val);

   // floor(sum/3) > x  <=>  sum >= 3x+3 ; floor(sum/3) < x  <=>  sum < 3x
   assign a_above = sum_val >= (a_x3 + SUM_W'(3));
   assign b_above = sum_val >= (b_x3 + SUM_W'(3));
   assign c_above = sum_val >= (c_x3 + SUM_W'(3));
   assign a_below = sum_val < a_x3;
   assign b_below = sum_val < b_x3;
   assign c_below = sum_val < c_x3;

   always_comb begin
      hit     = 1'b0;
      step_ok = 1'b1;
      unique case (state_cur.step)
         STEP_1: hit = c_above;
         STEP_2: hit = b_below;
         STEP_3: hit = a_above;
         STEP_4: hit = c_below;
         STEP_5: hit = b_above;
         STEP_6: hit = a_below;
         default: step_ok = 1'b0;
      endcase
   end

   always_comb begin
      fire       = 1'b0;
      state_next = state_cur;
      if (step_ok && hit) begin
         if (state_cur.count == filter_limit) begin
            fire             = 1'b1;
            state_next.count = '0;
            state_next.step  = (state_cur.step == STEP_LAST) ? STEP_FIRST
                                                             : state_cur.step + STEP_W'(1);
         end else begin
            state_next.count = state_cur.count + COUNT_W'(1);
         end
      end else begin
         state_next.count = '0;
      end
   end

   assign result.commutate     = fire;
   assign result.step_now      = state_next.step;
   assign result.qualify_count = state_next.count;

endmodule

### rtl/core/bemf_zero_cross_commutator.sv
// top level of the back-emf zero-crossing commutator: input register,
// step unit, result register; depends on bzc_pkg and bzc_step_unit
//
//   port group  | direction | payload
//   req_        | in        | bzc_req_type, three phase samples
//   rsp_        | out       | bzc_rsp_type, commutate, step, count
//   csr_        | in        | filter_limit, 8 bit
//
// rsp_valid rises once a req transfer has passed the input register and been written
// into the result register; one item per cycle sustained while rsp_ready stays high,
// since the compare and counter update in the step unit are combinational
// synchronous reset: step 1, counter 0, limit 3, both stages empty
// an rsp stall fills the input stage, then drops req_ready
module bemf_zero_cross_commutator #(
   parameter int SAMPLE_BITS = bzc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bzc_pkg::bzc_req_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output bzc_pkg::bzc_rsp_type        rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bzc_pkg::COUNT_W-1:0] csr_data
);
   import bzc_pkg::*;

   logic                in_vld_ff, in_vld_in;
   bzc_req_type         in_data_ff;
   logic                rsp_vld_ff, rsp_vld_in;
   bzc_rsp_type         rsp_data_ff, rsp_data_in;
   bzc_state_type       state_ff, state_in;
   logic [COUNT_W-1:0]  limit_ff;
   logic                advance;

   bzc_step_unit #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_step (
      .sample_data  (in_data_ff),
      .state_cur    (state_ff),
      .filter_limit (limit_ff),
      .state_next   (state_in),
      .result       (rsp_data_in)
   );

   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_ready) begin
         in_vld_in = req_valid;
      end
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         state_ff   <= '{step: STEP_FIRST, count: '0};
         limit_ff   <= LIMIT_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### rtl/core/bzc_checker.sv
// port-level checks for the back-emf zero-crossing commutator, bound to the top
// depends on bzc_pkg and bemf_zero_cross_commutator_defines.svh
`include "bemf_zero_cross_commutator_defines.svh"

module bzc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input bzc_pkg::bzc_rsp_type        rsp_data,
   input logic                        csr_ready
);
   import bzc_pkg::*;

   // stalled result holds
   `BZC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_data), "rsp changed while stalled")

   // a commutation restarts the filter
   `BZC_ASSERT_SAME(a_fire_clears, clock, reset, rsp_valid && rsp_data.commutate,
                    rsp_data.qualify_count == '0, "commutate with nonzero count")

   // step stays within one to six
   `BZC_ASSERT_SAME(a_step_range, clock, reset, rsp_valid,
                    rsp_data.step_now >= STEP_FIRST && rsp_data.step_now <= STEP_LAST,
                    "step out of range")

   // an empty result stage always takes a new transfer
   `BZC_ASSERT_SAME(a_req_open, clock, reset, !rsp_valid, req_ready && csr_ready,
                    "req_ready low with the result stage empty")

endmodule

bind bemf_zero_cross_commutator bzc_checker u_bzc_checker (.*);
